>>> rtl/scfc_pkg.sv
// ----------------------------------------------------------------------------
// Frame checker package
// Shared types, codes and constants for the delimited frame checker.
// ----------------------------------------------------------------------------
package scfc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_INDEX_W = 1;

  // Fixed frame overhead: two start, length, two checksum and two end bytes.
  localparam int unsigned FRAME_OVERHEAD = 7;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hFB;
  localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'hFE;

  localparam int unsigned QUEUE_DEPTH_DEFAULT  = 2;
  localparam int unsigned RESULT_DEPTH_DEFAULT = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE   = 1'b1;

  // Role of a byte inside the expected frame layout.
  typedef enum logic [2:0] {
    KIND_START,
    KIND_LENGTH,
    KIND_BODY,
    KIND_SUM_HI,
    KIND_SUM_LO,
    KIND_END,
    KIND_NONE
  } pos_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_BAD_START = 3'd2,
    STATUS_BAD_SUM   = 3'd3,
    STATUS_BAD_END   = 3'd4
  } status_t;

  // One classified byte, handed from the front end to the back end.
  typedef struct packed {
    pos_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              short_buf;
    logic              len_bad;
    logic [BYTE_W-1:0] length;
  } queue_entry_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] inner_length;
  } result_t;

endpackage

>>> rtl/scfc_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out queue in flip-flops; push and pop may happen together.
// ----------------------------------------------------------------------------
module scfc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/scfc_front.sv
// ----------------------------------------------------------------------------
// Frame checker front end
// Tracks the byte position and length byte and classifies every byte.
// ----------------------------------------------------------------------------
module scfc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [scfc_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         last,
  output scfc_pkg::queue_entry_t       entry
);
  import scfc_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] MIN_TOTAL = COUNT_W'(FRAME_OVERHEAD + 1);
  localparam logic [COUNT_W-1:0] OVERHEAD  = COUNT_W'(FRAME_OVERHEAD);

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [BYTE_W-1:0]  length_seen;
  logic [BYTE_W-1:0]  length_next;
  logic [COUNT_W-1:0] n_ext;
  logic [COUNT_W-1:0] len_ext;
  pos_kind_t          kind;

  assign n_ext = COUNT_W'(length_seen);

  always_comb begin
    if (byte_count < 16'd2) begin
      kind = KIND_START;
    end else if (byte_count == 16'd2) begin
      kind = KIND_LENGTH;
    end else if (byte_count <= n_ext + 16'd2) begin
      kind = KIND_BODY;
    end else if (byte_count == n_ext + 16'd3) begin
      kind = KIND_SUM_HI;
    end else if (byte_count == n_ext + 16'd4) begin
      kind = KIND_SUM_LO;
    end else if (byte_count == n_ext + 16'd5 || byte_count == n_ext + 16'd6) begin
      kind = KIND_END;
    end else begin
      kind = KIND_NONE;
    end
  end

  // Count including this byte, saturating; length as it stands after it.
  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;
  assign length_next     = (byte_count == 16'd2) ? data_byte : length_seen;
  assign len_ext         = COUNT_W'(length_next);

  always_comb begin
    entry.kind      = kind;
    entry.data      = data_byte;
    entry.last      = last;
    entry.short_buf = (byte_count_next < MIN_TOTAL);
    entry.len_bad   = (length_next == '0) || (len_ext + OVERHEAD > byte_count_next);
    entry.length    = length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      length_seen <= '0;
    end else if (accept) begin
      if (last) begin
        byte_count  <= '0;
        length_seen <= '0;
      end else begin
        byte_count  <= byte_count_next;
        length_seen <= length_next;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (byte_count == '0 && length_seen == '0))
    else $error("position state not cleared after the final byte");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    (accept && !last && byte_count == COUNT_MAX) |=> (byte_count == COUNT_MAX))
    else $error("byte count wrapped instead of saturating");

  a_length_capture: assert property (@(posedge clk) disable iff (rst)
    (accept && !last && byte_count == 16'd2) |=> (length_seen == $past(data_byte)))
    else $error("length byte not captured at its position");

endmodule

>>> rtl/scfc_back.sv
// ----------------------------------------------------------------------------
// Frame checker back end
// Keeps the running sum and mismatch flags and forms the final status.
// ----------------------------------------------------------------------------
module scfc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [scfc_pkg::BYTE_W-1:0]  start_byte,
  input  logic [scfc_pkg::BYTE_W-1:0]  end_byte,
  input  logic                         q_empty,
  input  scfc_pkg::queue_entry_t       q_entry,
  output logic                         q_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output scfc_pkg::result_t            res_data
);
  import scfc_pkg::*;

  logic [SUM_W-1:0] running_sum;
  logic [SUM_W-1:0] running_sum_next;
  logic             start_bad;
  logic             start_bad_next;
  logic             sum_bad;
  logic             sum_bad_next;
  logic             end_bad;
  logic             end_bad_next;

  // A final byte may only be taken when its result has somewhere to go.
  assign q_pop    = !q_empty && (!q_entry.last || !res_full);
  assign res_push = q_pop && q_entry.last;

  always_comb begin
    running_sum_next = running_sum;
    start_bad_next   = start_bad;
    sum_bad_next     = sum_bad;
    end_bad_next     = end_bad;
    case (q_entry.kind)
      KIND_START: begin
        if (q_entry.data != start_byte) start_bad_next = 1'b1;
      end
      KIND_LENGTH: begin
        running_sum_next = SUM_W'(q_entry.data);
      end
      KIND_BODY: begin
        running_sum_next = running_sum + SUM_W'(q_entry.data);
      end
      KIND_SUM_HI: begin
        if (q_entry.data != running_sum[SUM_W-1:BYTE_W]) sum_bad_next = 1'b1;
      end
      KIND_SUM_LO: begin
        if (q_entry.data != running_sum[BYTE_W-1:0]) sum_bad_next = 1'b1;
      end
      KIND_END: begin
        if (q_entry.data != end_byte) end_bad_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_data.inner_length = q_entry.length;
    if (q_entry.short_buf) begin
      res_data.status = STATUS_SHORT;
    end else if (start_bad_next) begin
      res_data.status = STATUS_BAD_START;
    end else if (q_entry.len_bad) begin
      res_data.status = STATUS_SHORT;
    end else if (sum_bad_next) begin
      res_data.status = STATUS_BAD_SUM;
    end else if (end_bad_next) begin
      res_data.status = STATUS_BAD_END;
    end else begin
      res_data.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      start_bad   <= 1'b0;
      sum_bad     <= 1'b0;
      end_bad     <= 1'b0;
    end else if (q_pop) begin
      if (q_entry.last) begin
        running_sum <= '0;
        start_bad   <= 1'b0;
        sum_bad     <= 1'b0;
        end_bad     <= 1'b0;
      end else begin
        running_sum <= running_sum_next;
        start_bad   <= start_bad_next;
        sum_bad     <= sum_bad_next;
        end_bad     <= end_bad_next;
      end
    end
  end

endmodule

>>> rtl/sum_checked_frame_checker.sv
// ----------------------------------------------------------------------------
// Delimited frame checker with 16-bit additive checksum
// Checks a received buffer byte by byte and reports one status per buffer.
// ----------------------------------------------------------------------------
// Usage: the block looks like a queue on both sides. A byte transaction is
// taken at a clock edge where push is high and full is low; last marks the
// final byte of a buffer. Only a final byte produces a result transaction.
// The result (status and inner_length) is shown while empty is low and is
// removed at an edge where pop is high.
// A final byte passes through the middle queue and the back end into the
// result queue. Throughput is one byte per cycle, set by the running sum in
// the back end, which retires one byte from the middle queue each cycle.
// When the receiver stalls, up to two results wait in the result queue; the
// back end then holds the next final byte, the middle queue fills and full
// rises. Other bytes keep flowing as long as the middle queue has room.
// Reset (rst, synchronous) empties both queues, clears the position counter,
// sum and flags, and restores start_byte to 0xFB and end_byte to 0xFE.
// The user must write configuration through cfg_write, cfg_index and cfg_data
// only while no buffer is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sum_checked_frame_checker #(
  parameter int unsigned QUEUE_DEPTH  = scfc_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int unsigned RESULT_DEPTH = scfc_pkg::RESULT_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_write,
  input  logic [scfc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scfc_pkg::BYTE_W-1:0]      cfg_data,
  // Byte input
  input  logic                             push,
  output logic                             full,
  input  logic [scfc_pkg::BYTE_W-1:0]      data_byte,
  input  logic                             last,
  // Result output
  output logic                             empty,
  input  logic                             pop,
  output logic [scfc_pkg::STATUS_W-1:0]    status,
  output logic [scfc_pkg::BYTE_W-1:0]      inner_length
);
  import scfc_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;

  logic              accept;
  queue_entry_t      front_entry;
  queue_entry_t      q_entry;
  logic [$bits(queue_entry_t)-1:0] q_rd;
  logic              q_empty;
  logic              q_pop;

  logic              res_full;
  logic              res_push;
  result_t           res_data;
  result_t           res_out;
  logic [$bits(result_t)-1:0] res_rd;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
      end_byte   <= END_BYTE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  // Front end: position tracking and byte classification.
  scfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last      (last),
    .entry     (front_entry)
  );

  // Middle queue decouples classification from checking.
  scfc_fifo #(
    .WIDTH ($bits(queue_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_entry),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  assign q_entry = queue_entry_t'(q_rd);

  // Back end: running sum, mismatch flags and status.
  scfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte),
    .end_byte   (end_byte),
    .q_empty    (q_empty),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  // Result queue doubles as the output register.
  scfc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign res_out      = result_t'(res_rd);
  assign status       = res_out.status;
  assign inner_length = res_out.inner_length;

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!res_full && !q_empty && q_entry.last))
    else $error("result produced without a final byte or without room");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(inner_length)))
    else $error("waiting result changed before it was taken");

endmodule
